[sv/mmst_pkg.sv]
// Shared types and constants for the multi-mode session timer.
// Used by mmst_csr, mmst_core and multi_mode_session_timer; no dependencies.
package mmst_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned COUNT_W     = 16;

   localparam logic [1:0] MODE_ELAPSED   = 2'd0;
   localparam logic [1:0] MODE_REMAINING = 2'd1;
   localparam logic [1:0] MODE_ALTERNATE = 2'd2;
   localparam logic [1:0] MODE_RESERVED  = 2'd3;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_PAUSE   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;
   localparam logic [1:0] OP_NEXT    = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTDOWN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORK      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BREAK     = 2'd3;

   localparam logic [TIME_W-1:0] WORK_DEFAULT_MS  = TIME_W'(25 * 60 * 1000);
   localparam logic [TIME_W-1:0] BREAK_DEFAULT_MS = TIME_W'(5 * 60 * 1000);

   typedef struct packed {
      logic [1:0]        operation;
      logic [TICK_W-1:0] tick_amount;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]  time_value;
      logic               paused;
      logic               finished;
      logic               phase;
      logic [COUNT_W-1:0] work_count;
      logic               finish_event;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [TIME_W-1:0] countdown_start;
      logic [TIME_W-1:0] work_length;
      logic [TIME_W-1:0] break_length;
   } cfg_type;

endpackage

[sv/mmst_csr.sv]
// Configuration register bank of the session timer.
// Depends on mmst_pkg.
module mmst_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [mmst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mmst_pkg::CSR_DATA_W-1:0]  csr_data,
   output mmst_pkg::cfg_type                cfg
);

   mmst_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            mmst_pkg::CSR_MODE:      cfg_in.mode            = csr_data[1:0];
            mmst_pkg::CSR_COUNTDOWN: cfg_in.countdown_start = csr_data;
            mmst_pkg::CSR_WORK:      cfg_in.work_length     = csr_data;
            mmst_pkg::CSR_BREAK:     cfg_in.break_length    = csr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode            <= mmst_pkg::MODE_ELAPSED;
         cfg_ff.countdown_start <= '0;
         cfg_ff.work_length     <= mmst_pkg::WORK_DEFAULT_MS;
         cfg_ff.break_length    <= mmst_pkg::BREAK_DEFAULT_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/mmst_core.sv]
// Timer state and the per-word update: tick, pause, restart, next phase.
// Depends on mmst_pkg.
module mmst_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  mmst_pkg::req_type req,
   input  mmst_pkg::cfg_type cfg,
   output mmst_pkg::rsp_type rsp
);

   logic [mmst_pkg::TIME_W-1:0]  time_ff, time_in;
   logic                         pause_ff, pause_in;
   logic                         done_ff, done_in;
   logic                         phase_ff, phase_in;
   logic [mmst_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         event_w;

   logic [mmst_pkg::TIME_W:0]   sum;
   logic [mmst_pkg::TIME_W-1:0] amount;
   logic                        running;

   assign amount  = mmst_pkg::TIME_W'(req.tick_amount);
   assign sum     = {1'b0, time_ff} + {1'b0, amount};
   assign running = !pause_ff && !done_ff;

   always_comb begin
      time_in  = time_ff;
      pause_in = pause_ff;
      done_in  = done_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      event_w  = 1'b0;
      case (req.operation)
         mmst_pkg::OP_TICK: begin
            if (running) begin
               case (cfg.mode) inside
                  mmst_pkg::MODE_ELAPSED: begin
                     time_in = sum[mmst_pkg::TIME_W] ? '1 : sum[mmst_pkg::TIME_W-1:0];
                  end
                  mmst_pkg::MODE_REMAINING, mmst_pkg::MODE_ALTERNATE: begin
                     if (time_ff <= amount) begin
                        time_in = '0;
                        done_in = 1'b1;
                        event_w = 1'b1;
                     end else begin
                        time_in = time_ff - amount;
                     end
                  end
                  default: time_in = time_ff;
               endcase
            end
         end
         mmst_pkg::OP_PAUSE: pause_in = !pause_ff;
         mmst_pkg::OP_RESTART: begin
            done_in = 1'b0;
            case (cfg.mode)
               mmst_pkg::MODE_ELAPSED:   time_in = '0;
               mmst_pkg::MODE_REMAINING: time_in = cfg.countdown_start;
               mmst_pkg::MODE_ALTERNATE:
                  time_in = phase_ff ? cfg.break_length : cfg.work_length;
               default: time_in = time_ff;
            endcase
         end
         default: begin
            // next phase, alternation mode only
            if (cfg.mode == mmst_pkg::MODE_ALTERNATE) begin
               done_in  = 1'b0;
               phase_in = !phase_ff;
               if (!phase_ff && (count_ff != '1)) begin
                  count_in = count_ff + 1'b1;
               end
               time_in = phase_ff ? cfg.work_length : cfg.break_length;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= '0;
         pause_ff <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         count_ff <= '0;
      end else if (step) begin
         time_ff  <= time_in;
         pause_ff <= pause_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      rsp.time_value   = time_in;
      rsp.paused       = pause_in;
      rsp.finished     = done_in;
      rsp.phase        = phase_in;
      rsp.work_count   = count_in;
      rsp.finish_event = event_w;
   end

endmodule

[sv/multi_mode_session_timer.sv]
// Top level of the multi-mode session timer: input register, update, result register.
// Depends on mmst_pkg, mmst_csr and mmst_core.

// Session timer with stopwatch, countdown and work/break alternation modes, time in
// milliseconds. Every accepted request word gives one response word carrying the
// state after the operation. One word per cycle sustained while rsp_stall is low; each
// word goes through the input register and the result register around the update
// (one 32-bit add or subtract and compare). Stall on the response side backs up into
// req_stall only when both registers hold words. Configuration is written through
// csr_write/csr_index/csr_data and should change only while the timer is idle.
module multi_mode_session_timer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  mmst_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mmst_pkg::rsp_type                rsp_data,
   input  logic                             csr_write,
   input  logic [mmst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mmst_pkg::CSR_DATA_W-1:0]  csr_data
);

   mmst_pkg::cfg_type cfg;
   mmst_pkg::rsp_type result;

   logic              in_valid_ff, in_valid_in;
   mmst_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   mmst_pkg::rsp_type out_data_ff;
   logic              advance;
   logic              accept;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   mmst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mmst_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[test/tb_multi_mode_session_timer.sv]
// Self-checking testbench for multi_mode_session_timer: directed and random request words
// against a timer predictor, with random valid gaps and response stalls.
// Depends on mmst_pkg and the multi_mode_session_timer RTL.
module tb_multi_mode_session_timer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CSR_INDEX_W = mmst_pkg::CSR_INDEX_W;
   localparam int unsigned CSR_DATA_W  = mmst_pkg::CSR_DATA_W;
   localparam int unsigned TIME_W      = mmst_pkg::TIME_W;
   localparam int unsigned TICK_W      = mmst_pkg::TICK_W;
   localparam int unsigned COUNT_W     = mmst_pkg::COUNT_W;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   mmst_pkg::req_type      req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   mmst_pkg::rsp_type      rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   multi_mode_session_timer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   mmst_pkg::req_type req_backlog[$];
   mmst_pkg::rsp_type predicted_rsp[$];
   int unsigned sender_idle_pct = 37;
   int unsigned recv_stall_pct  = 82;
   int unsigned error_count = 0;
   int unsigned rsp_seen = 0;
   logic        req_fired = 1'b0;

   // timer shadow state
   mmst_pkg::cfg_type  cfg = '{mmst_pkg::MODE_ELAPSED, '0, mmst_pkg::WORK_DEFAULT_MS,
                               mmst_pkg::BREAK_DEFAULT_MS};
   logic [TIME_W-1:0]  run_time = '0;
   logic               run_paused = 1'b0;
   logic               run_done = 1'b0;
   logic               run_phase = 1'b0;
   logic [COUNT_W-1:0] run_work_count = '0;

   function automatic logic [TIME_W-1:0] phase_span();
      return run_phase ? cfg.break_length : cfg.work_length;
   endfunction

   function automatic mmst_pkg::rsp_type advance_timer(mmst_pkg::req_type word);
      mmst_pkg::rsp_type r;
      logic [TIME_W:0]   sum;
      r = '0;
      case (word.operation)
         mmst_pkg::OP_TICK: begin
            if (!run_paused && !run_done) begin
               if (cfg.mode == mmst_pkg::MODE_ELAPSED) begin
                  sum = {1'b0, run_time} + (TIME_W + 1)'(word.tick_amount);
                  run_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
               end else if (cfg.mode == mmst_pkg::MODE_REMAINING ||
                            cfg.mode == mmst_pkg::MODE_ALTERNATE) begin
                  if (run_time <= TIME_W'(word.tick_amount)) begin
                     run_time = '0;
                     run_done = 1'b1;
                     r.finish_event = 1'b1;
                  end else begin
                     run_time = run_time - TIME_W'(word.tick_amount);
                  end
               end
            end
         end
         mmst_pkg::OP_PAUSE: run_paused = ~run_paused;
         mmst_pkg::OP_RESTART: begin
            run_done = 1'b0;
            if (cfg.mode == mmst_pkg::MODE_ELAPSED) run_time = '0;
            else if (cfg.mode == mmst_pkg::MODE_REMAINING) run_time = cfg.countdown_start;
            else if (cfg.mode == mmst_pkg::MODE_ALTERNATE) run_time = phase_span();
         end
         mmst_pkg::OP_NEXT: begin
            if (cfg.mode == mmst_pkg::MODE_ALTERNATE) begin
               if (!run_phase) begin
                  if (run_work_count != '1) run_work_count = run_work_count + 1'b1;
                  run_phase = 1'b1;
               end else begin
                  run_phase = 1'b0;
               end
               run_done = 1'b0;
               run_time = phase_span();
            end
         end
      endcase
      r.time_value = run_time;
      r.paused     = run_paused;
      r.finished   = run_done;
      r.phase      = run_phase;
      r.work_count = run_work_count;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < 40) $display("ERROR word %0d: %s", rsp_seen, msg);
      error_count++;
   endtask

   // response check, then request acceptance
   always @(posedge clock) begin : monitor
      mmst_pkg::rsp_type want;
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected word %p", rsp_data));
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_data.time_value !== want.time_value)
                  report_mismatch($sformatf("time_value %0d, expected %0d",
                                            rsp_data.time_value, want.time_value));
               if (rsp_data.paused !== want.paused)
                  report_mismatch($sformatf("paused %b, expected %b",
                                            rsp_data.paused, want.paused));
               if (rsp_data.finished !== want.finished)
                  report_mismatch($sformatf("finished %b, expected %b",
                                            rsp_data.finished, want.finished));
               if (rsp_data.phase !== want.phase)
                  report_mismatch($sformatf("phase %b, expected %b",
                                            rsp_data.phase, want.phase));
               if (rsp_data.work_count !== want.work_count)
                  report_mismatch($sformatf("work_count %0d, expected %0d",
                                            rsp_data.work_count, want.work_count));
               if (rsp_data.finish_event !== want.finish_event)
                  report_mismatch($sformatf("finish_event %b, expected %b",
                                            rsp_data.finish_event, want.finish_event));
            end
            rsp_seen++;
         end
         req_fired = req_valid && !req_stall;
         if (req_fired) predicted_rsp.push_back(advance_timer(req_data));
      end
   end

   always @(negedge clock) begin : driver
      logic              nxt_valid;
      mmst_pkg::req_type nxt_data;
      nxt_valid = req_valid;
      nxt_data  = req_data;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_valid || req_fired) begin
         nxt_valid = 1'b0;
         if (req_backlog.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
            nxt_data  = req_backlog.pop_front();
            nxt_valid = 1'b1;
         end
      end
      req_valid <= nxt_valid;
      req_data  <= nxt_data;
      rsp_stall <= !reset && ($urandom_range(99, 0) < recv_stall_pct);
   end

   task automatic add_req(logic [1:0] op, logic [TICK_W-1:0] amount);
      mmst_pkg::req_type w;
      w.operation   = op;
      w.tick_amount = amount;
      req_backlog.push_back(w);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         mmst_pkg::CSR_MODE:      cfg.mode = value[1:0];
         mmst_pkg::CSR_COUNTDOWN: cfg.countdown_start = value;
         mmst_pkg::CSR_WORK:      cfg.work_length = value;
         mmst_pkg::CSR_BREAK:     cfg.break_length = value;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_mode(logic [1:0] m);
      write_csr(mmst_pkg::CSR_MODE, CSR_DATA_W'(m));
   endtask

   task automatic settle();
      while (req_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [TIME_W-1:0] pick_length();
      case ($urandom_range(9, 0))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3:       return $urandom;
         4:       return 32'hFFFF_0000 | $urandom_range(65535, 0);
         default: return $urandom_range(250000, 1);
      endcase
   endfunction

   initial begin : stimulus
      int unsigned pick;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // stopwatch at reset values
      add_req(mmst_pkg::OP_TICK, 16'd0);
      add_req(mmst_pkg::OP_TICK, 16'hFFFF);
      add_req(mmst_pkg::OP_PAUSE, 16'd0);
      add_req(mmst_pkg::OP_TICK, 16'd100);
      add_req(mmst_pkg::OP_PAUSE, 16'hFFFF);
      add_req(mmst_pkg::OP_NEXT, 16'd0);
      add_req(mmst_pkg::OP_RESTART, 16'd0);
      settle();
      // alternation with default lengths, pause kept across next
      write_mode(mmst_pkg::MODE_ALTERNATE);
      add_req(mmst_pkg::OP_RESTART, 16'd0);
      add_req(mmst_pkg::OP_TICK, 16'hFFFF);
      add_req(mmst_pkg::OP_NEXT, 16'd0);
      add_req(mmst_pkg::OP_NEXT, 16'd0);
      add_req(mmst_pkg::OP_PAUSE, 16'd0);
      add_req(mmst_pkg::OP_NEXT, 16'd0);
      add_req(mmst_pkg::OP_PAUSE, 16'd0);
      settle();
      // zero countdown: zero tick finishes, then finished tick is ignored
      write_csr(mmst_pkg::CSR_COUNTDOWN, '0);
      write_mode(mmst_pkg::MODE_REMAINING);
      add_req(mmst_pkg::OP_RESTART, 16'd0);
      add_req(mmst_pkg::OP_TICK, 16'd0);
      add_req(mmst_pkg::OP_TICK, 16'd5);
      settle();
      // unused mode: restart clears finished only
      write_mode(mmst_pkg::MODE_RESERVED);
      add_req(mmst_pkg::OP_RESTART, 16'd0);
      add_req(mmst_pkg::OP_TICK, 16'd7);
      add_req(mmst_pkg::OP_NEXT, 16'd0);
      settle();
      // stopwatch saturation, loaded through a countdown restart
      write_csr(mmst_pkg::CSR_COUNTDOWN, '1);
      write_mode(mmst_pkg::MODE_REMAINING);
      add_req(mmst_pkg::OP_RESTART, 16'd0);
      settle();
      write_mode(mmst_pkg::MODE_ELAPSED);
      add_req(mmst_pkg::OP_TICK, 16'hFFFF);
      settle();
      // zero phase lengths
      write_csr(mmst_pkg::CSR_WORK, '0);
      write_csr(mmst_pkg::CSR_BREAK, '0);
      write_mode(mmst_pkg::MODE_ALTERNATE);
      add_req(mmst_pkg::OP_RESTART, 16'd0);
      add_req(mmst_pkg::OP_TICK, 16'd0);
      add_req(mmst_pkg::OP_NEXT, 16'd0);
      add_req(mmst_pkg::OP_TICK, 16'd40);
      settle();

      for (int seg = 0; seg < 12; seg++) begin
         sender_idle_pct = (seg < 4) ? 37 : (seg < 8) ? 82 : 0;
         recv_stall_pct  = (seg < 4) ? 82 : (seg < 8) ? 37 : 0;
         write_mode(($urandom_range(9, 0) == 0) ? mmst_pkg::MODE_RESERVED
                                                : 2'($urandom_range(2, 0)));
         write_csr(mmst_pkg::CSR_COUNTDOWN, pick_length());
         write_csr(mmst_pkg::CSR_WORK, pick_length());
         write_csr(mmst_pkg::CSR_BREAK, pick_length());
         add_req(mmst_pkg::OP_RESTART, 16'($urandom_range(65535, 0)));
         for (int k = 1; k < 125; k++) begin
            pick = $urandom_range(99, 0);
            if (pick < 66)
               add_req(mmst_pkg::OP_TICK,
                       ($urandom_range(3, 0) == 0) ? 16'($urandom_range(255, 0))
                                                   : 16'($urandom_range(65535, 0)));
            else if (pick < 72)
               add_req(mmst_pkg::OP_PAUSE, 16'($urandom_range(65535, 0)));
            else if (pick < 86)
               add_req(mmst_pkg::OP_RESTART, 16'($urandom_range(65535, 0)));
            else
               add_req(mmst_pkg::OP_NEXT, 16'($urandom_range(65535, 0)));
         end
         settle();
      end

      if (error_count == 0) begin
         $display("** multi_mode_session_timer: PASSED **");
      end else begin
         $display("** multi_mode_session_timer: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("** multi_mode_session_timer: FAILED **");
      $finish;
   end

endmodule
